>>> sv/fp8dq_pkg.sv
// ----------------------------------------------------------------------------
// fp8dq_pkg: shared types and constants
// FP32 field constants and sequencer state type for the FP8 dequant dot product.
// ----------------------------------------------------------------------------
package fp8dq_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] BF16_ROUND_BIAS = 32'h0000_7FFF;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1
    } fpu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_WS,
        ST_MUL_ACT,
        ST_ADD,
        ST_OUT
    } state_t;

    // exact E4M3 to FP32
    function automatic logic [31:0] e4m3_decode(input logic [7:0] code);
        logic        s;
        logic [3:0]  ex;
        logic [2:0]  man;
        logic [31:0] r;
        s   = code[7];
        ex  = code[6:3];
        man = code[2:0];
        if (ex == 4'hF && man == 3'h7) begin
            r = QNAN;
        end else if (ex == 4'h0) begin
            if (man[2]) begin
                r = {s, 8'd120, man[1:0], 21'd0};
            end else if (man[1]) begin
                r = {s, 8'd119, man[0], 22'd0};
            end else if (man[0]) begin
                r = {s, 8'd118, 23'd0};
            end else begin
                r = {s, 31'd0};
            end
        end else begin
            r = {s, 4'd0, ex, man, 20'd0} + {1'b0, 8'd120, 23'd0};
        end
        return r;
    endfunction

endpackage

>>> sv/fp8dq_fpu.sv
// ----------------------------------------------------------------------------
// fp8dq_fpu: shared FP32 multiply / add unit
// One operation per request, IEEE round-to-nearest-even, subnormals kept,
// NaN results canonical. The result is registered and appears in the cycle after the request.
// ----------------------------------------------------------------------------
module fp8dq_fpu
    import fp8dq_pkg::*;
(
    input  logic        aclk,
    input  fpu_op_t     op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [31:0] y_reg;
    logic [31:0] y_next;
    assign y = y_reg;

    always_ff @(posedge aclk) begin
        y_reg <= y_next;
    end

    // shared normalize and round: value = mag * 2^(e - 150), mag has sticky at bit 0
    function automatic logic [31:0] pack_rne(input logic s, input logic signed [10:0] e,
                                              input logic [49:0] mag);
        logic [49:0]        m;
        logic signed [10:0] ee;
        logic [5:0]         lz;
        logic [5:0]         sh;
        logic [49:0]        t;
        logic               st;
        logic [24:0]        keep;
        logic               g;
        logic               rs;
        logic [24:0]        rnd;
        logic [31:0]        r;
        m  = mag;
        lz = 6'd0;
        for (int i = 49; i >= 0; i--) begin
            if (m[i] && lz == 6'd0) lz = 6'(50 - i);
        end
        if (m == 50'd0) begin
            r = {s, 31'd0};
        end else begin
            // put leading one at bit 49
            m  = m << (lz - 6'd1);
            // ee: biased exponent, leading one sits at bit 50 - lz of mag
            ee = e + 11'sd27 - $signed({5'd0, lz});
            if (ee < 11'sd1) begin
                sh = (ee < -11'sd30) ? 6'd32 : 6'(11'sd1 - ee);
                st = 1'b0;
                for (int i = 0; i < 50; i++) begin
                    if (i < sh && m[i]) st = 1'b1;
                end
                t  = m >> sh;
                m  = {t[49:1], t[0] | st};
                ee = 11'sd0;
            end
            keep = {1'b0, m[49:26]};
            g    = m[25];
            rs   = |m[24:0];
            rnd  = keep + 25'(g && (rs || keep[0]));
            if (rnd[24]) begin
                rnd = rnd >> 1;
                ee  = ee + 11'sd1;
            end else if (ee == 11'sd0 && rnd[23]) begin
                ee = 11'sd1;
            end
            if (ee >= 11'sd255) r = {s, 8'hFF, 23'd0};
            else r = {s, ee[7:0], rnd[22:0]};
        end
        return r;
    endfunction

    always_comb begin
        logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic signed [10:0] xa, xb;
        logic [47:0] p;
        logic [49:0] big, sml, sm2;
        logic signed [10:0] xe;
        logic [10:0] d;
        logic        stk, sr;
        logic [31:0] ta, tb;
        sa = a[31]; sb = b[31];
        ea = a[30:23]; eb = b[30:23];
        nan_a = (ea == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (eb == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (ea == 8'hFF) && !nan_a;
        inf_b = (eb == 8'hFF) && !nan_b;
        zer_a = a[30:0] == 31'd0;
        zer_b = b[30:0] == 31'd0;
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        xa = (ea == 8'd0) ? 11'sd1 : $signed({3'd0, ea});
        xb = (eb == 8'd0) ? 11'sd1 : $signed({3'd0, eb});
        p = 48'd0; big = 50'd0; sml = 50'd0; sm2 = 50'd0; xe = 11'sd0; d = 11'd0;
        stk = 1'b0; sr = 1'b0; ta = a; tb = b;
        y_next = 32'd0;
        unique case (op)
            OP_MUL: begin
                if (nan_a || nan_b || (inf_a && zer_b) || (inf_b && zer_a)) begin
                    y_next = QNAN;
                end else if (inf_a || inf_b) begin
                    y_next = {sa ^ sb, 8'hFF, 23'd0};
                end else begin
                    p = ma * mb;
                    // value = p * 2^(xa+xb-300), mag = 4p, so e = xa+xb-152
                    y_next = pack_rne(sa ^ sb, xa + xb - 11'sd152, {p, 2'b00});
                end
            end
            OP_ADD: begin
                if (nan_a || nan_b || (inf_a && inf_b && sa != sb)) begin
                    y_next = QNAN;
                end else if (inf_a) begin
                    y_next = a;
                end else if (inf_b) begin
                    y_next = b;
                end else if (zer_a && zer_b) begin
                    y_next = {sa & sb, 31'd0};
                end else begin
                    if ({xa, ma} < {xb, mb}) begin
                        ta = b; tb = a;
                        big = {1'b0, mb, 25'd0}; sml = {1'b0, ma, 25'd0};
                        xe = xb; d = 11'(xb - xa); sr = sb;
                    end else begin
                        big = {1'b0, ma, 25'd0}; sml = {1'b0, mb, 25'd0};
                        xe = xa; d = 11'(xa - xb); sr = sa;
                    end
                    if (d > 11'd49) begin
                        stk = sml != 50'd0; sm2 = 50'd0;
                    end else begin
                        for (int i = 0; i < 50; i++) begin
                            if (i < d && sml[i]) stk = 1'b1;
                        end
                        sm2 = sml >> d;
                    end
                    sm2 = {sm2[49:1], sm2[0] | stk};
                    if (ta[31] == tb[31]) big = big + sm2;
                    else big = big - sm2;
                    // operands sit 25 bits up, so e = xe - 25
                    if (big == 50'd0) y_next = 32'd0;
                    else y_next = pack_rne(sr, xe - 11'sd25, big);
                end
            end
            default: y_next = 32'd0;
        endcase
    end

endmodule

>>> sv/fp8_dequant_bf16_dot_product_top.sv
// ----------------------------------------------------------------------------
// fp8_dequant_bf16_dot_product_top: FP8 E4M3 block-scaled dot product, BF16 out
// Decodes weight, scales, multiplies by activation, accumulates in FP32.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tlast
// s_      | in  | activation[15:0], weight_code[23:16],    | last_term
//         |     | block_scale[55:24]                       |
// m_      | out | product_bf16[15:0]                       | -
// Each request uses the one shared FP32 mul/add unit in turn (scale multiply,
// activation multiply, accumulate), then writes back in ST_OUT, so a new
// request is taken only after that write-back. On the last term m_tvalid
// rises from ov_reg, which is set in ST_OUT. s_tready is high only in idle with no result
// waiting; the result holds in m_ until taken. Reset clears the accumulator to +0.
module fp8_dequant_bf16_dot_product_top
    import fp8dq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // activation, weight_code, block_scale
    input  logic        s_tlast,  // last_term
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // product_bf16
);

    state_t      state_reg, state_next;
    logic [31:0] act_reg, w_reg, scale_reg, sum_reg;
    logic        last_reg;
    logic [15:0] out_reg;
    logic        ov_reg;
    fpu_op_t     op;
    logic [31:0] fa, fb, fy;
    logic [31:0] t;

    fp8dq_fpu u_fpu (.aclk(aclk), .op(op), .a(fa), .b(fb), .y(fy));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid && s_tready) state_next = ST_MUL_WS;
            ST_MUL_WS:  state_next = ST_MUL_ACT;
            ST_MUL_ACT: state_next = ST_ADD;
            ST_ADD:     state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op = OP_MUL; fa = w_reg; fb = scale_reg;
        unique case (state_reg)
            ST_MUL_ACT: begin op = OP_MUL; fa = act_reg; fb = fy; end
            ST_ADD:     begin op = OP_ADD; fa = sum_reg; fb = fy; end
            default:    begin op = OP_MUL; fa = w_reg; fb = scale_reg; end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
    assign t = fy + BF16_ROUND_BIAS + {31'd0, fy[16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= 32'd0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            if (state_reg == ST_OUT) begin
                if (last_reg) begin
                    sum_reg <= 32'd0;
                    out_reg <= t[31:16];
                    ov_reg  <= 1'b1;
                end else begin
                    sum_reg <= fy;
                end
            end
        end
        if (s_tvalid && s_tready) begin
            act_reg   <= {s_tdata[15:0], 16'd0};
            w_reg     <= e4m3_decode(s_tdata[23:16]);
            scale_reg <= s_tdata[55:24];
            last_reg  <= s_tlast;
        end
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && last_reg) |=> m_tvalid) else $error("no result");
    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && last_reg) |=> sum_reg == 32'd0) else $error("sum kept");

endmodule
